// ===== rtl/core/lsp_pkg.sv =====
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    localparam opcode_t OP_GRANT   = 2'd0;
    localparam opcode_t OP_ACCESS  = 2'd1;
    localparam opcode_t OP_RELEASE = 2'd2;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_NO_FREE = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic link1;
        logic link2;
        logic load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip;
        logic out_ready;
    } stat_t;

endpackage

// ===== rtl/core/lsp_ctrl.sv =====
`timescale 1ns / 1ps

module lsp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lsp_pkg::stat_t stat,
    output lsp_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_LINK1  = 5'b00100,
        S_LINK2  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = stat.skip ? S_RESULT : S_LINK1;
            end
            S_LINK1:
            begin
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.decode = (state_reg == S_DECODE);
    assign cmd.link1  = (state_reg == S_LINK1);
    assign cmd.link2  = (state_reg == S_LINK2);
    assign cmd.load   = (state_reg == S_RESULT) && stat.out_ready;

endmodule

// ===== rtl/core/lsp_datapath.sv =====
`timescale 1ns / 1ps

module lsp_datapath
#(
    parameter int SLOTS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  lsp_pkg::cfg_t    active_slots,
    input  lsp_pkg::opcode_t opcode,
    input  lsp_pkg::index_t  slot_index,
    input  logic             out_stall,
    output logic             out_valid,
    output lsp_pkg::status_t status,
    output lsp_pkg::index_t  granted_slot,
    input  lsp_pkg::cmd_t    cmd,
    output lsp_pkg::stat_t   stat
);

    localparam int LW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int RESET_N = (SLOTS < 64) ? SLOTS : 64;

    // list state
    logic [CW-1:0]    active_reg;
    logic [LW-1:0]    head_reg;
    logic [LW-1:0]    tail_reg;
    logic [SLOTS-1:0] free_reg;

    // link arrays; an entry not yet written reads as its restart value
    logic [LW-1:0]    next_link_reg [SLOTS];
    logic [LW-1:0]    prev_link_reg [SLOTS];
    logic [SLOTS-1:0] next_vld_reg;
    logic [SLOTS-1:0] prev_vld_reg;
    logic [LW-1:0]    next_rd_reg;
    logic [LW-1:0]    prev_rd_reg;
    logic             next_rvld_reg;
    logic             prev_rvld_reg;
    logic [LW-1:0]    raddr_reg;

    // item registers
    lsp_pkg::opcode_t op_reg;
    lsp_pkg::index_t  idx_reg;
    logic [LW-1:0]    slot_reg;
    logic             to_head_reg;
    logic             hit_end_reg;
    lsp_pkg::status_t res_status_reg;
    lsp_pkg::index_t  res_grant_reg;

    // output register
    logic             out_valid_reg;
    lsp_pkg::status_t out_status_reg;
    lsp_pkg::index_t  out_grant_reg;

    logic [CW-1:0]    cfg_n;
    logic             is_grant;
    logic             is_release;
    logic             op_bad;
    logic             idx_bad;
    logic [LW-1:0]    s_eff;
    logic             no_move;
    logic             hit_end;
    lsp_pkg::status_t dec_status;
    logic [LW-1:0]    nx;
    logic [LW-1:0]    pv;

    logic             next_we;
    logic [LW-1:0]    next_wa;
    logic [LW-1:0]    next_wd;
    logic             prev_we;
    logic [LW-1:0]    prev_wa;
    logic [LW-1:0]    prev_wd;

    always_comb
    begin
        if (active_slots == '0)
        begin
            cfg_n = CW'(1);
        end
        else if (32'(active_slots) > 32'(SLOTS))
        begin
            cfg_n = CW'(SLOTS);
        end
        else
        begin
            cfg_n = CW'(active_slots);
        end
    end

    // decode
    always_comb
    begin
        is_grant   = (op_reg == lsp_pkg::OP_GRANT);
        is_release = (op_reg == lsp_pkg::OP_RELEASE);
        op_bad     = !(op_reg inside {lsp_pkg::OP_GRANT, lsp_pkg::OP_ACCESS,
                                      lsp_pkg::OP_RELEASE});
        idx_bad    = !is_grant && (32'(idx_reg) >= 32'(active_reg));
        s_eff      = is_grant ? head_reg : LW'(idx_reg);
        no_move    = is_release ? (s_eff == head_reg) : (s_eff == tail_reg);
        hit_end    = is_release ? (s_eff == tail_reg) : (s_eff == head_reg);
        if (op_bad || idx_bad)
        begin
            dec_status = lsp_pkg::ST_RANGE;
        end
        else if (is_grant && !free_reg[head_reg])
        begin
            dec_status = lsp_pkg::ST_NO_FREE;
        end
        else
        begin
            dec_status = lsp_pkg::ST_DONE;
        end
    end

    assign stat.skip      = (dec_status != lsp_pkg::ST_DONE) || no_move;
    assign stat.out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= opcode;
            idx_reg <= slot_index;
        end
        if (cmd.decode)
        begin
            slot_reg       <= s_eff;
            to_head_reg    <= is_release;
            hit_end_reg    <= hit_end;
            res_status_reg <= dec_status;
            res_grant_reg  <= (is_grant && dec_status == lsp_pkg::ST_DONE) ?
                              lsp_pkg::index_t'(head_reg) : '0;
        end
    end

    // link read data, restart value where the entry is not valid
    always_comb
    begin
        if (next_rvld_reg)
        begin
            nx = next_rd_reg;
        end
        else if (32'(raddr_reg) + 32'd1 == 32'(active_reg))
        begin
            nx = '0;
        end
        else
        begin
            nx = LW'(32'(raddr_reg) + 32'd1);
        end
        if (prev_rvld_reg)
        begin
            pv = prev_rd_reg;
        end
        else if (raddr_reg == '0)
        begin
            pv = LW'(active_reg - CW'(1));
        end
        else
        begin
            pv = raddr_reg - LW'(1);
        end
    end

    // link writes: unlink in the first step, splice at head or tail in the second
    always_comb
    begin
        next_we = 1'b0;
        next_wa = pv;
        next_wd = nx;
        prev_we = 1'b0;
        prev_wa = nx;
        prev_wd = pv;
        if (cmd.link1 && !hit_end_reg)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end
        else if (cmd.link2)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
            if (to_head_reg)
            begin
                next_wa = slot_reg;
                next_wd = head_reg;
                prev_wa = head_reg;
                prev_wd = slot_reg;
            end
            else
            begin
                next_wa = tail_reg;
                next_wd = slot_reg;
                prev_wa = slot_reg;
                prev_wd = tail_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_link_reg[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_link_reg[prev_wa] <= prev_wd;
        end
        if (cmd.decode)
        begin
            next_rd_reg   <= next_link_reg[s_eff];
            prev_rd_reg   <= prev_link_reg[s_eff];
            next_rvld_reg <= next_vld_reg[s_eff];
            prev_rvld_reg <= prev_vld_reg[s_eff];
            raddr_reg     <= s_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= CW'(RESET_N);
            head_reg     <= '0;
            tail_reg     <= LW'(RESET_N - 1);
            free_reg     <= '1;
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            active_reg   <= cfg_n;
            head_reg     <= '0;
            tail_reg     <= LW'(cfg_n - CW'(1));
            free_reg     <= '1;
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
        end
        else
        begin
            if (next_we)
            begin
                next_vld_reg[next_wa] <= 1'b1;
            end
            if (prev_we)
            begin
                prev_vld_reg[prev_wa] <= 1'b1;
            end
            if (cmd.decode && dec_status == lsp_pkg::ST_DONE)
            begin
                if (is_grant)
                begin
                    free_reg[head_reg] <= 1'b0;
                end
                else if (is_release)
                begin
                    free_reg[s_eff] <= 1'b1;
                end
            end
            if (cmd.link1 && hit_end_reg)
            begin
                if (to_head_reg)
                begin
                    tail_reg <= pv;
                end
                else
                begin
                    head_reg <= nx;
                end
            end
            if (cmd.link2)
            begin
                if (to_head_reg)
                begin
                    head_reg <= slot_reg;
                end
                else
                begin
                    tail_reg <= slot_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_slot = out_grant_reg;

endmodule

// ===== rtl/core/lru_slot_pool_unit.sv =====
`timescale 1ns / 1ps

// LRU slot pool: keeps slots in least-to-most-recently-used order with a free
// mark per slot. Opcode grant takes the head slot if free, access moves a slot
// to the tail, release moves it to the head and frees it. Each item is taken
// in the idle state and then decoded; if links must move, the LINK1 and LINK2
// states rewrite them, since each link array has a single write port. The
// result state then loads the result register, holding a waiting result while
// the output side stalls; no new item is taken before that load. Writing
// active_slots restarts the order (0 to N-1, all free) through per-entry
// valid bits; write it only while no item is in flight.
module lru_slot_pool_unit
#(
    parameter int SLOTS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  lsp_pkg::cfg_t    active_slots,
    input  logic             in_valid,
    output logic             in_stall,
    input  lsp_pkg::opcode_t opcode,
    input  lsp_pkg::index_t  slot_index,
    output logic             out_valid,
    input  logic             out_stall,
    output lsp_pkg::status_t status,
    output lsp_pkg::index_t  granted_slot
);

    lsp_pkg::cmd_t  cmd;
    lsp_pkg::stat_t stat;

    lsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsp_datapath
    #(
        .SLOTS (SLOTS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .active_slots (active_slots),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .granted_slot (granted_slot),
        .cmd          (cmd),
        .stat         (stat)
    );

    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after transfer");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("result load did not raise out_valid");

    a_grant_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted_slot != '0) |-> (status == lsp_pkg::ST_DONE))
        else $error("granted slot with failing status");

endmodule
